@@ sv/tpo_pkg.sv @@
package tpo_pkg;

    // number of vertices per triangle
    localparam int NUM_VERT = 3;

    // sign of one orientation determinant
    typedef struct packed {
        logic neg;
        logic zero;
    } sgn_t;

    // signs of all edge and vertex tests for one triangle pair
    typedef struct packed {
        sgn_t [NUM_VERT-1:0][NUM_VERT-1:0] eo;
        sgn_t [NUM_VERT-1:0][NUM_VERT-1:0] vo;
    } orient_set_t;

    // column of the edge table for each vertex of triangle A
    localparam logic [1:0] A_P = 2'd0;
    localparam logic [1:0] A_Q = 2'd1;
    localparam logic [1:0] A_R = 2'd2;

    // column of the vertex table
    localparam logic [1:0] V_PQ = 2'd0;  // orient(a0, b, a1)
    localparam logic [1:0] V_PR = 2'd1;  // orient(a0, b, a2)
    localparam logic [1:0] V_QR = 2'd2;  // orient(a1, a2, b)

    function automatic logic ge0(input sgn_t s);
        return !s.neg;
    endfunction

    function automatic logic le0(input sgn_t s);
        return s.neg || s.zero;
    endfunction

    function automatic logic gt0(input sgn_t s);
        return !s.neg && !s.zero;
    endfunction

endpackage

@@ sv/tpo_in_if.sv @@
interface tpo_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a0_x;
    logic signed [COORD_BITS-1:0] a0_y;
    logic signed [COORD_BITS-1:0] a1_x;
    logic signed [COORD_BITS-1:0] a1_y;
    logic signed [COORD_BITS-1:0] a2_x;
    logic signed [COORD_BITS-1:0] a2_y;
    logic signed [COORD_BITS-1:0] b0_x;
    logic signed [COORD_BITS-1:0] b0_y;
    logic signed [COORD_BITS-1:0] b1_x;
    logic signed [COORD_BITS-1:0] b1_y;
    logic signed [COORD_BITS-1:0] b2_x;
    logic signed [COORD_BITS-1:0] b2_y;

    modport source (
        output valid, a0_x, a0_y, a1_x, a1_y, a2_x, a2_y,
        output b0_x, b0_y, b1_x, b1_y, b2_x, b2_y,
        input  ready
    );
    modport sink (
        input  valid, a0_x, a0_y, a1_x, a1_y, a2_x, a2_y,
        input  b0_x, b0_y, b1_x, b1_y, b2_x, b2_y,
        output ready
    );
endinterface

@@ sv/tpo_out_if.sv @@
interface tpo_out_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (
        output valid, overlap,
        input  ready
    );
    modport sink (
        input  valid, overlap,
        output ready
    );
endinterface

@@ sv/triangle_pair_overlap_2d.sv @@
// channel   modport  beat
// pair      sink     a0..a2, b0..b2 vertex coordinates, signed
// result    source   overlap flag
//
// one pair per cycle sustained while the result is taken; a beat that is taken
// passes through the input register, then the result register, to its result
// all 18 orientation tests work in parallel between those two registers
// rst_n clears both valid flags asynchronously; payload is not reset
// a stalled result holds; the input register still takes one beat while
// empty, then ready drops until the result moves on
module triangle_pair_overlap_2d
    import tpo_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tpo_in_if.sink        pair,
    tpo_out_if.source     result
);
    logic signed [COORD_BITS-1:0] ax_reg [NUM_VERT];
    logic signed [COORD_BITS-1:0] ay_reg [NUM_VERT];
    logic signed [COORD_BITS-1:0] bx_reg [NUM_VERT];
    logic signed [COORD_BITS-1:0] by_reg [NUM_VERT];
    logic        in_valid_reg, in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        overlap_reg, overlap_next;
    logic        res_take;
    logic        in_take;
    orient_set_t os;

    // handshake: the result register frees when empty or being taken
    assign res_take   = !out_valid_reg || result.ready;
    assign pair.ready = !in_valid_reg || res_take;
    assign in_take    = pair.valid && pair.ready;

    assign in_valid_next  = pair.ready ? pair.valid : in_valid_reg;
    assign out_valid_next = res_take ? in_valid_reg : out_valid_reg;

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ax_reg[0] <= pair.a0_x;
            ay_reg[0] <= pair.a0_y;
            ax_reg[1] <= pair.a1_x;
            ay_reg[1] <= pair.a1_y;
            ax_reg[2] <= pair.a2_x;
            ay_reg[2] <= pair.a2_y;
            bx_reg[0] <= pair.b0_x;
            by_reg[0] <= pair.b0_y;
            bx_reg[1] <= pair.b1_x;
            by_reg[1] <= pair.b1_y;
            bx_reg[2] <= pair.b2_x;
            by_reg[2] <= pair.b2_y;
        end
    end

    // orientation of each directed edge of b against each vertex of a
    for (genvar i = 0; i < NUM_VERT; i++)
    begin : g_edge
        localparam int NI = (i + 1) % NUM_VERT;
        for (genvar k = 0; k < NUM_VERT; k++)
        begin : g_avert
            tpo_orient #(.COORD_BITS(COORD_BITS)) u_orient (
                .ax   (bx_reg[i]),
                .ay   (by_reg[i]),
                .bx   (bx_reg[NI]),
                .by   (by_reg[NI]),
                .cx   (ax_reg[k]),
                .cy   (ay_reg[k]),
                .sign (os.eo[i][k])
            );
        end
    end

    // orientation of each vertex of b against the edges of a
    for (genvar j = 0; j < NUM_VERT; j++)
    begin : g_bvert
        tpo_orient #(.COORD_BITS(COORD_BITS)) u_pq (
            .ax   (ax_reg[0]),
            .ay   (ay_reg[0]),
            .bx   (bx_reg[j]),
            .by   (by_reg[j]),
            .cx   (ax_reg[1]),
            .cy   (ay_reg[1]),
            .sign (os.vo[j][V_PQ])
        );
        tpo_orient #(.COORD_BITS(COORD_BITS)) u_pr (
            .ax   (ax_reg[0]),
            .ay   (ay_reg[0]),
            .bx   (bx_reg[j]),
            .by   (by_reg[j]),
            .cx   (ax_reg[2]),
            .cy   (ay_reg[2]),
            .sign (os.vo[j][V_PR])
        );
        tpo_orient #(.COORD_BITS(COORD_BITS)) u_qr (
            .ax   (ax_reg[1]),
            .ay   (ay_reg[1]),
            .bx   (ax_reg[2]),
            .by   (ay_reg[2]),
            .cx   (bx_reg[j]),
            .cy   (by_reg[j]),
            .sign (os.vo[j][V_QR])
        );
    end

    // decision tree
    tpo_decide u_decide (
        .os      (os),
        .overlap (overlap_next)
    );

    // result register payload
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            overlap_reg <= overlap_next;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.overlap = overlap_reg;
endmodule

@@ sv/tpo_orient.sv @@
module tpo_orient
    import tpo_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output sgn_t                         sign
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] ux, uy, vx, vy;
    logic signed [PW-1:0] p, q;
    logic signed [PW:0]   det;

    // exact (b-a) x (c-a), wide enough for any coordinates
    assign ux  = DW'(bx) - DW'(ax);
    assign uy  = DW'(by) - DW'(ay);
    assign vx  = DW'(cx) - DW'(ax);
    assign vy  = DW'(cy) - DW'(ay);
    assign p   = PW'(ux) * PW'(vy);
    assign q   = PW'(uy) * PW'(vx);
    assign det = (PW+1)'(p) - (PW+1)'(q);

    assign sign.neg  = det[PW];
    assign sign.zero = (det == '0);
endmodule

@@ sv/tpo_decide.sv @@
module tpo_decide
    import tpo_pkg::*;
(
    input  orient_set_t os,
    output logic        overlap
);
    // a0 in the vertex region at b[p]; q, r follow counterclockwise
    function automatic logic vertex_region(
        input orient_set_t s,
        input logic [1:0]  p,
        input logic [1:0]  q,
        input logic [1:0]  r
    );
        logic res;
        if (ge0(s.eo[r][A_Q])) begin
            if (ge0(s.eo[q][A_Q])) begin
                if (gt0(s.vo[p][V_PQ]))
                    res = le0(s.vo[q][V_PQ]);
                else
                    res = ge0(s.vo[p][V_PR]) && ge0(s.vo[p][V_QR]);
            end
            else begin
                res = le0(s.vo[q][V_PQ]) && ge0(s.eo[q][A_R]) && ge0(s.vo[q][V_QR]);
            end
        end
        else if (ge0(s.eo[r][A_R])) begin
            if (ge0(s.vo[r][V_QR]))
                res = ge0(s.vo[p][V_PR]);
            else
                res = ge0(s.vo[q][V_QR]) && ge0(s.eo[q][A_R]);
        end
        else begin
            res = 1'b0;
        end
        return res;
    endfunction

    // a0 in the edge region of the edge from b[y] to b[x]
    function automatic logic edge_region(
        input orient_set_t s,
        input logic [1:0]  x,
        input logic [1:0]  y
    );
        logic res;
        if (ge0(s.eo[y][A_Q])) begin
            if (ge0(s.vo[x][V_PQ]))
                res = le0(s.vo[y][V_PQ]);
            else
                res = ge0(s.vo[x][V_QR]) && ge0(s.vo[x][V_PR]);
        end
        else begin
            res = ge0(s.eo[y][A_R]) && ge0(s.vo[x][V_PR]) &&
                  (le0(s.vo[y][V_PR]) || ge0(s.vo[y][V_QR]));
        end
        return res;
    endfunction

    logic c0, c1, c2;

    // where a0 lies against each edge of b
    assign c0 = ge0(os.eo[0][A_P]);
    assign c1 = ge0(os.eo[1][A_P]);
    assign c2 = ge0(os.eo[2][A_P]);

    // region selection and the matching decision tree
    always_comb
    begin
        case ({c0, c1, c2})
            3'b111:  overlap = 1'b1;
            3'b110:  overlap = edge_region(os, 2'd0, 2'd2);
            3'b101:  overlap = edge_region(os, 2'd2, 2'd1);
            3'b100:  overlap = vertex_region(os, 2'd0, 2'd1, 2'd2);
            3'b011:  overlap = edge_region(os, 2'd1, 2'd0);
            3'b010:  overlap = vertex_region(os, 2'd1, 2'd2, 2'd0);
            default: overlap = vertex_region(os, 2'd2, 2'd0, 2'd1);
        endcase
    end
endmodule

@@ dv/triangle_pair_overlap_2d_tb.sv @@
`timescale 1ns / 1ps

module triangle_pair_overlap_2d_tb;
    import tpo_pkg::NUM_VERT;

    localparam int COORD_BITS  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int COORD_MIN   = -(2 ** (COORD_BITS - 1));
    localparam int COORD_MAX   = 2 ** (COORD_BITS - 1) - 1;

    typedef logic signed [COORD_BITS-1:0]   coord_t;
    // wide enough for the exact cross product of the edge vectors
    typedef logic signed [2*COORD_BITS+3:0] wide_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vtx_t;

    typedef vtx_t [NUM_VERT-1:0] shape_t;

    typedef struct packed {
        shape_t a;
        shape_t b;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n;

    tpo_in_if #(.COORD_BITS(COORD_BITS)) pair_bus ();
    tpo_out_if                           result_bus ();

    triangle_pair_overlap_2d #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_bus),
        .result (result_bus)
    );

    // expected overlap flags, oldest first
    bit overlap_q[$];

    bit no_idle = 1'b0;
    bit result_taken = 1'b0;
    int ready_hold = 0;
    int cycle_cnt = 0;
    int pairs_sent = 0;
    int flags_checked = 0;
    int hits_seen = 0;
    int fail_cnt = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // orientation of (b-a) x (c-a), exact
    function automatic int turn(vtx_t a, vtx_t b, vtx_t c);
        wide_t det;
        det = (wide_t'($signed(b.x)) - wide_t'($signed(a.x)))
                * (wide_t'($signed(c.y)) - wide_t'($signed(a.y)))
            - (wide_t'($signed(b.y)) - wide_t'($signed(a.y)))
                * (wide_t'($signed(c.x)) - wide_t'($signed(a.x)));
        if (det > 0)
            return 1;
        if (det < 0)
            return -1;
        return 0;
    endfunction

    // a0 sits in the region beyond a corner of b
    function automatic bit corner_region_hit(vtx_t p1, vtx_t q1, vtx_t r1,
                                             vtx_t p2, vtx_t q2, vtx_t r2);
        if (turn(r2, p2, q1) >= 0)
        begin
            if (turn(r2, q2, q1) <= 0)
            begin
                if (turn(p1, p2, q1) > 0)
                    return turn(p1, q2, q1) <= 0;
                return turn(p1, p2, r1) >= 0 && turn(q1, r1, p2) >= 0;
            end
            return turn(p1, q2, q1) <= 0 && turn(r2, q2, r1) <= 0 &&
                   turn(q1, r1, q2) >= 0;
        end
        if (turn(r2, p2, r1) >= 0)
        begin
            if (turn(q1, r1, r2) >= 0)
                return turn(p1, p2, r1) >= 0;
            return turn(q1, r1, q2) >= 0 && turn(r2, r1, q2) >= 0;
        end
        return 1'b0;
    endfunction

    // a0 sits in the region beyond an edge of b
    function automatic bit side_region_hit(vtx_t p1, vtx_t q1, vtx_t r1,
                                           vtx_t p2, vtx_t r2);
        if (turn(r2, p2, q1) >= 0)
        begin
            if (turn(p1, p2, q1) >= 0)
                return turn(p1, q1, r2) >= 0;
            return turn(q1, r1, p2) >= 0 && turn(r1, p1, p2) >= 0;
        end
        if (turn(r2, p2, r1) >= 0 && turn(p1, p2, r1) >= 0)
            return turn(p1, r1, r2) >= 0 || turn(q1, r1, r2) >= 0;
        return 1'b0;
    endfunction

    // classify a0 against b, rotate b and pick the decision tree
    function automatic bit triangles_overlap(pair_t pr);
        vtx_t p1, q1, r1, p2, q2, r2;
        p1 = pr.a[0];
        q1 = pr.a[1];
        r1 = pr.a[2];
        p2 = pr.b[0];
        q2 = pr.b[1];
        r2 = pr.b[2];
        if (turn(p2, q2, p1) >= 0)
        begin
            if (turn(q2, r2, p1) >= 0)
            begin
                if (turn(r2, p2, p1) >= 0)
                    return 1'b1;
                return side_region_hit(p1, q1, r1, p2, r2);
            end
            if (turn(r2, p2, p1) >= 0)
                return side_region_hit(p1, q1, r1, r2, q2);
            return corner_region_hit(p1, q1, r1, p2, q2, r2);
        end
        if (turn(q2, r2, p1) >= 0)
        begin
            if (turn(r2, p2, p1) >= 0)
                return side_region_hit(p1, q1, r1, q2, p2);
            return corner_region_hit(p1, q1, r1, q2, r2, p2);
        end
        return corner_region_hit(p1, q1, r1, r2, p2, q2);
    endfunction

    function automatic int idle_cycles();
        if (no_idle)
            return 0;
        return int'($urandom_range(0, 6));
    endfunction

    function automatic pair_t pair_from(int ax0, int ay0, int ax1, int ay1,
                                        int ax2, int ay2, int bx0, int by0,
                                        int bx1, int by1, int bx2, int by2);
        pair_t pr;
        pr.a[0] = '{x: coord_t'(ax0), y: coord_t'(ay0)};
        pr.a[1] = '{x: coord_t'(ax1), y: coord_t'(ay1)};
        pr.a[2] = '{x: coord_t'(ax2), y: coord_t'(ay2)};
        pr.b[0] = '{x: coord_t'(bx0), y: coord_t'(by0)};
        pr.b[1] = '{x: coord_t'(bx1), y: coord_t'(by1)};
        pr.b[2] = '{x: coord_t'(bx2), y: coord_t'(by2)};
        return pr;
    endfunction

    // random coordinate around a centre, clipped to the coordinate range
    function automatic coord_t jitter(int centre, int span);
        int v;
        v = centre + int'($urandom_range(0, 2 * span)) - span;
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return coord_t'(v);
    endfunction

    // most triangles are put in counterclockwise order, a few are left as drawn
    function automatic shape_t mostly_ccw(shape_t s);
        vtx_t t;
        if ($urandom_range(0, 7) != 0 && turn(s[0], s[1], s[2]) < 0)
        begin
            t    = s[1];
            s[1] = s[2];
            s[2] = t;
        end
        return s;
    endfunction

    function automatic pair_t random_pair(int cx, int cy, int span);
        pair_t pr;
        int bx, by;
        bx = cx + int'($urandom_range(0, span)) - span / 2;
        by = cy + int'($urandom_range(0, span)) - span / 2;
        for (int i = 0; i < NUM_VERT; i++)
        begin
            pr.a[i].x = jitter(cx, span);
            pr.a[i].y = jitter(cy, span);
            pr.b[i].x = jitter(bx, span);
            pr.b[i].y = jitter(by, span);
        end
        pr.a = mostly_ccw(pr.a);
        pr.b = mostly_ccw(pr.b);
        return pr;
    endfunction

    function automatic int random_centre();
        return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
    endfunction

    // send one pair beat, called and returning on a falling edge
    task automatic drive_pair(input pair_t pr);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            pair_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pair_bus.a0_x  <= pr.a[0].x;
        pair_bus.a0_y  <= pr.a[0].y;
        pair_bus.a1_x  <= pr.a[1].x;
        pair_bus.a1_y  <= pr.a[1].y;
        pair_bus.a2_x  <= pr.a[2].x;
        pair_bus.a2_y  <= pr.a[2].y;
        pair_bus.b0_x  <= pr.b[0].x;
        pair_bus.b0_y  <= pr.b[0].y;
        pair_bus.b1_x  <= pr.b[1].x;
        pair_bus.b1_y  <= pr.b[1].y;
        pair_bus.b2_x  <= pr.b[2].x;
        pair_bus.b2_y  <= pr.b[2].y;
        pair_bus.valid <= 1'b1;
        @(posedge clk);
        while (!pair_bus.ready)
            @(posedge clk);
        overlap_q.push_back(triangles_overlap(pr));
        pairs_sent++;
        @(negedge clk);
    endtask

    // compare each result beat with the oldest expected flag
    always @(posedge clk)
    begin
        bit want;
        result_taken = rst_n && result_bus.valid && result_bus.ready;
        if (result_taken)
        begin
            if (overlap_q.size() == 0)
            begin
                $error("overlap: result beat with nothing expected, actual %0b",
                       result_bus.overlap);
                fail_cnt++;
            end
            else
            begin
                want = overlap_q.pop_front();
                flags_checked++;
                if (result_bus.overlap)
                    hits_seen++;
                if (result_bus.overlap !== want)
                begin
                    $error("overlap: expected %0b, actual %0b", want,
                           result_bus.overlap);
                    fail_cnt++;
                end
            end
        end
    end

    // result back-pressure, a fresh wait drawn after every result beat
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_taken)
                ready_hold = idle_cycles();
            if (ready_hold > 0)
            begin
                result_bus.ready <= 1'b0;
                ready_hold = ready_hold - 1;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // full-scale coordinates, coincident points and far corners
    task automatic test_extremes();
        drive_pair(pair_from(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                             COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        drive_pair(pair_from(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                             COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        drive_pair(pair_from(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                             COORD_MAX, COORD_MAX, -COORD_MAX, COORD_MAX, COORD_MAX, -COORD_MAX));
        drive_pair(pair_from(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                             COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        drive_pair(pair_from(0, 0, 0, 0, 0, 0, -1, -1, 1, -1, -1, 1));
        drive_pair(pair_from(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN, COORD_MIN,
                             COORD_MIN + 1, COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX,
                             COORD_MAX, COORD_MAX - 1));
    endtask

    // a0 in each region of b, touching, containment, odd winding, degenerates
    task automatic test_regions();
        drive_pair(pair_from(2, 2, 4, 2, 2, 4, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(8, -4, 12, -2, 10, 4, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(8, -4, 12, -4, 10, -1, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(12, 12, 10, 12, 12, 10, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(12, 12, 2, 6, 6, 2, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(-4, 8, -1, 6, -1, 10, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(-4, 8, 0, 6, 0, 10, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(-4, -4, 4, -2, -2, 4, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(-4, -4, -1, -4, -4, -1, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(20, -2, 22, 4, 14, 2, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(-2, 20, -4, 14, 2, 12, 0, 0, 16, 0, 0, 16));
        // shared corner and shared edge
        drive_pair(pair_from(16, 0, 24, 0, 20, 8, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(0, -8, 16, -8, 8, 0, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(0, 0, 16, 0, 0, 16, 0, 0, 16, 0, 0, 16));
        // clockwise winding on one or both sides
        drive_pair(pair_from(2, 2, 2, 4, 4, 2, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(2, 2, 2, 4, 4, 2, 0, 0, 0, 16, 16, 0));
        // collinear segment and single point
        drive_pair(pair_from(-4, 4, 4, 4, 20, 4, 0, 0, 16, 0, 0, 16));
        drive_pair(pair_from(0, 0, 16, 0, 0, 16, 4, 4, 4, 4, 4, 4));
        // one step short of touching
        drive_pair(pair_from(9, 8, 20, 8, 9, 20, 0, 0, 16, 0, 0, 16));
    endtask

    // tiny grid round the origin: many shared points and collinear edges
    task automatic test_random_grid(input int count);
        for (int i = 0; i < count; i++)
            drive_pair(random_pair(0, 0, int'($urandom_range(2, 8))));
    endtask

    // clusters at random places and scales, clipping at the range edges
    task automatic test_random_cluster(input int count);
        int span;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: span = 16;
                1: span = 256;
                2: span = 4096;
                default: span = 32768;
            endcase
            drive_pair(random_pair(random_centre(), random_centre(), span));
        end
    endtask

    // raw coordinates over the whole range, every bit toggling
    task automatic test_random_full_range(input int count);
        pair_t pr;
        for (int i = 0; i < count; i++)
        begin
            for (int v = 0; v < NUM_VERT; v++)
            begin
                pr.a[v].x = coord_t'($urandom);
                pr.a[v].y = coord_t'($urandom);
                pr.b[v].x = coord_t'($urandom);
                pr.b[v].y = coord_t'($urandom);
            end
            pr.a = mostly_ccw(pr.a);
            pr.b = mostly_ccw(pr.b);
            drive_pair(pr);
        end
    endtask

    // one beat per cycle with no back-pressure
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        test_random_grid(count / 2);
        test_random_cluster(count - count / 2);
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        result_bus.ready = 1'b0;
        pair_bus.valid   = 1'b0;
        pair_bus.a0_x    = '0;
        pair_bus.a0_y    = '0;
        pair_bus.a1_x    = '0;
        pair_bus.a1_y    = '0;
        pair_bus.a2_x    = '0;
        pair_bus.a2_y    = '0;
        pair_bus.b0_x    = '0;
        pair_bus.b0_y    = '0;
        pair_bus.b1_x    = '0;
        pair_bus.b1_y    = '0;
        pair_bus.b2_x    = '0;
        pair_bus.b2_y    = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_regions();
        test_random_grid(200);
        test_random_cluster(250);
        test_back_to_back(150);
        test_random_full_range(100);

        // drain
        pair_bus.valid <= 1'b0;
        while (overlap_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d pairs sent: corners, region cases, grid, clusters, back-to-back, full range",
                 pairs_sent);
        $display("%0d flags checked (%0d overlapping, %0d apart), %0d mismatches",
                 flags_checked, hits_seen, flags_checked - hits_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
